/* hw/rtl/fcbf_pkg.sv */
// Shared types and constants for the flow-controlled byte FIFO.
// Used by fcbf_ram users and the top level; no dependencies.
package fcbf_pkg;

  // Byte store geometry
  localparam int DEPTH = 4096;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int OPW  = 3;
  localparam int BW   = 8;
  localparam int OFFW = 12;
  localparam int CW   = 13;
  localparam int STW  = 2;
  localparam int TW   = 64;

  // Working width for level/count/capacity compares
  localparam int XW = (LW > CW) ? LW : CW;

  // Packed stream widths, rounded up to bytes
  localparam int IN_BITS  = OPW + BW + OFFW + CW;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STW + BW + 3 * CW + 2 * TW + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OPW-1:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_PEEK   = 3'd2,
    OP_POP    = 3'd3,
    OP_END    = 3'd4,
    OP_STATUS = 3'd5
  } op_t;

  typedef enum logic [STW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One result without the data byte, which is taken from the store read separately
  typedef struct packed {
    status_t         status;
    logic [CW-1:0]   popped;
    logic [CW-1:0]   fill_level;
    logic [CW-1:0]   free_space;
    logic [TW-1:0]   total_written;
    logic [TW-1:0]   total_read;
    logic            end_marked;
    logic            at_eof;
  } res_t;

endpackage

/* hw/rtl/flow_controlled_byte_fifo_unit.sv */
// Top level of the flow-controlled byte FIFO: pointer/level/total logic
// around one byte store. Depends on fcbf_pkg and fcbf_ram.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: opcode, byte, offset, count
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: one result per request
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_data: capacity
//
// For each request, the accept cycle updates pointers and totals and issues
// the store access, and the next cycle collects the store's registered read
// data into the output register.
// A new request is taken when no request is pending between accept and
// output, and the output register is empty or being drained.
// Reset (rst, synchronous) empties the FIFO, clears totals and the end flag,
// and sets capacity to 4096; store contents are left as they are.
module flow_controlled_byte_fifo_unit (
  input  logic clk,
  input  logic rst,
  // opcode[2:0], data_byte[10:3], offset[22:11], count[35:23], zero pad
  input  logic [fcbf_pkg::IN_W-1:0]  s_tdata,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // status[1:0], data_out[9:2], popped[22:10], fill_level[35:23],
  // free_space[48:36], total_written[112:49], total_read[176:113],
  // end_marked[177], at_eof[178], zero pad
  output logic [fcbf_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [fcbf_pkg::CW-1:0]    cfg_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready
);
  import fcbf_pkg::*;

  // request fields
  op_t             in_op;
  logic [BW-1:0]   in_byte;
  logic [OFFW-1:0] in_off;
  logic [CW-1:0]   in_cnt;

  // architectural state
  logic [CW-1:0] capacity;
  logic [AW-1:0] head;
  logic [LW-1:0] level;
  logic [TW-1:0] wr_total;
  logic [TW-1:0] rd_total;
  logic          ended;

  // pending slot between accept and output
  logic pend;
  logic pend_use_ram;
  res_t pend_res;
  res_t out_res;
  logic [BW-1:0] out_byte;

  // next-state and store access
  logic [AW-1:0] head_next;
  logic [LW-1:0] level_next;
  logic [TW-1:0] wr_total_next;
  logic [TW-1:0] rd_total_next;
  logic          ended_next;
  logic [XW-1:0] eff_cap;
  logic [XW-1:0] lvl_x;
  logic [XW-1:0] lvl_next_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pop_n;
  status_t       st;
  logic          use_ram;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [BW-1:0] ram_q;
  logic          accept;

  assign in_op   = op_t'(s_tdata[OPW-1:0]);
  assign in_byte = s_tdata[OPW +: BW];
  assign in_off  = s_tdata[OPW+BW +: OFFW];
  assign in_cnt  = s_tdata[OPW+BW+OFFW +: CW];

  assign cfg_ready = 1'b1;
  assign s_tready  = !pend && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;

  // effective capacity and widened operands
  always_comb begin
    eff_cap = (XW'(capacity) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(capacity);
    lvl_x   = XW'(level);
    cnt_x   = XW'(in_cnt);
  end

  // request decode and state update
  always_comb begin
    head_next     = head;
    level_next    = level;
    wr_total_next = wr_total;
    rd_total_next = rd_total;
    ended_next    = ended;
    st            = ST_DONE;
    use_ram       = 1'b0;
    ram_we        = 1'b0;
    pop_n         = '0;
    ram_waddr     = head + AW'(level);
    ram_raddr     = head;
    case (in_op)
      OP_WRITE: begin
        if (lvl_x < eff_cap) begin
          ram_we        = 1'b1;
          level_next    = level + LW'(1);
          wr_total_next = wr_total + TW'(1);
        end else begin
          st = ST_FULL;
        end
      end
      OP_READ: begin
        if (level != '0) begin
          use_ram = 1'b1;
          pop_n   = XW'(1);
        end else begin
          st = ST_EMPTY;
        end
      end
      OP_PEEK: begin
        ram_raddr = head + AW'(in_off);
        if (XW'(in_off) < lvl_x) begin
          use_ram = 1'b1;
        end else begin
          st = ST_EMPTY;
        end
      end
      OP_POP: begin
        pop_n = (cnt_x < lvl_x) ? cnt_x : lvl_x;
      end
      OP_END: begin
        ended_next = 1'b1;
      end
      default: begin
      end
    endcase
    if (in_op == OP_READ || in_op == OP_POP) begin
      head_next     = head + AW'(pop_n);
      level_next    = level - LW'(pop_n);
      rd_total_next = rd_total + TW'(pop_n);
    end
    lvl_next_x = XW'(level_next);
  end

  // byte store
  fcbf_ram #(
    .WIDTH(BW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept && ram_we),
    .waddr(ram_waddr),
    .wdata(in_byte),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(4096);
      head     <= '0;
      level    <= '0;
      wr_total <= '0;
      rd_total <= '0;
      ended    <= 1'b0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        head     <= head_next;
        level    <= level_next;
        wr_total <= wr_total_next;
        rd_total <= rd_total_next;
        ended    <= ended_next;
      end
      pend <= accept;
      if (pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_use_ram           <= use_ram;
      pend_res.status        <= st;
      pend_res.popped        <= CW'(pop_n);
      pend_res.fill_level    <= CW'(level_next);
      pend_res.free_space    <= (lvl_next_x < eff_cap) ? CW'(eff_cap - lvl_next_x) : '0;
      pend_res.total_written <= wr_total_next;
      pend_res.total_read    <= rd_total_next;
      pend_res.end_marked    <= ended_next;
      pend_res.at_eof        <= ended_next && (level_next == '0);
    end
    if (pend) begin
      out_res  <= pend_res;
      out_byte <= pend_use_ram ? ram_q : '0;
    end
  end

  // pack output fields, status in the lowest bits
  assign m_tdata = OUT_W'({out_res.at_eof, out_res.end_marked, out_res.total_read,
                           out_res.total_written, out_res.free_space, out_res.fill_level,
                           out_res.popped, out_byte, out_res.status});

endmodule

/* hw/rtl/fcbf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module fcbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
